FILE: rtl/core/k2p_pair_distance_defines.svh
// Assertion macros for the pair distance block.
`ifndef K2P_PAIR_DISTANCE_DEFINES_SVH
`define K2P_PAIR_DISTANCE_DEFINES_SVH
`ifndef SYNTHESIS
`define K2P_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("k2p assertion");
`define K2P_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("k2p assertion");
`else
`define K2P_ASSERT(label, clk, rst_n, prop)
`define K2P_ASSERT_NR(label, clk, prop)
`endif
`endif

FILE: rtl/core/k2p_pkg.sv
// Package with shared types and constants for the pair distance block.
`timescale 1ns / 1ps
package k2p_pkg;
    localparam int CntW = 17;
    localparam int DistW = 24;
    localparam int DefaultMaxColumns = 65536;
    localparam logic [31:0] Ln2Q32 = 32'd2977044472;
    localparam logic [1:0] StatusOk = 2'd0;
    localparam logic [1:0] StatusLogArg = 2'd1;
    localparam logic [1:0] StatusNoCols = 2'd2;

    typedef struct packed {
        logic [CntW-1:0] n;
        logic [CntW-1:0] ts;
        logic [CntW-1:0] tv;
    } counts_t;
endpackage

FILE: rtl/core/k2p_front.sv
// Front end: classifies columns, keeps the three counts, emits totals on the last column.
`timescale 1ns / 1ps
module k2p_front
    import k2p_pkg::*;
#(
    parameter int MAX_COLUMNS = DefaultMaxColumns
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [7:0]    base_a,
    input  logic [7:0]    base_b,
    input  logic          last,
    output logic          out_valid,
    output counts_t       out_counts
);
    localparam int CapI = (MAX_COLUMNS < 131071) ? MAX_COLUMNS : 131071;
    localparam logic [CntW-1:0] Cap = CntW'(CapI);

    logic [CntW-1:0] n_reg, ts_reg, tv_reg;
    logic [CntW-1:0] n_next, ts_next, tv_next;
    logic [2:0] ca, cb;

    function automatic logic [2:0] code(input logic [7:0] c);
        case (c)
            8'h41: code = 3'b100;
            8'h47: code = 3'b101;
            8'h43: code = 3'b110;
            8'h54: code = 3'b111;
            default: code = 3'b000;
        endcase
    endfunction

    always_comb
    begin
        ca = code(base_a);
        cb = code(base_b);
        n_next = n_reg;
        ts_next = ts_reg;
        tv_next = tv_reg;
        if (n_reg < Cap)
        begin
            n_next = n_reg + 1'b1;
            if (ca[2] && cb[2] && ca[1:0] != cb[1:0])
            begin
                if (ca[1] == cb[1])
                    ts_next = ts_reg + 1'b1;
                else
                    tv_next = tv_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= '0;
            ts_reg <= '0;
            tv_reg <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            out_valid <= in_valid && last;
            if (in_valid)
            begin
                if (last)
                begin
                    n_reg <= '0;
                    ts_reg <= '0;
                    tv_reg <= '0;
                end
                else
                begin
                    n_reg <= n_next;
                    ts_reg <= ts_next;
                    tv_reg <= tv_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && last)
            out_counts <= '{n: n_next, ts: ts_next, tv: tv_next};
    end
endmodule

FILE: rtl/core/k2p_queue.sv
// Small queue of count sets between the front end and the distance engine.
`timescale 1ns / 1ps
module k2p_queue
    import k2p_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr,
    input  counts_t wdata,
    output logic    full,
    output logic    empty,
    input  logic    rd,
    output counts_t rdata
);
    counts_t mem [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign full = cnt_reg >= 3'd3;
    assign empty = cnt_reg == 3'd0;
    assign rdata = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {2'b0, wr} - {2'b0, rd};
        end
    end
endmodule

FILE: rtl/core/k2p_back.sv
// Distance engine: three iterative log2 evaluations and the final scaling.
`timescale 1ns / 1ps
module k2p_back
    import k2p_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_empty,
    input  counts_t         in_counts,
    output logic            in_pop,
    output logic            res_valid,
    input  logic            res_pop,
    output counts_t         res_counts,
    output logic [DistW-1:0] res_dist,
    output logic [1:0]      res_status
);
    typedef enum logic [2:0] {S_IDLE, S_NORM, S_SQ, S_SUM, S_MUL, S_PROD, S_RND, S_OUT} state_t;
    state_t state_reg;

    counts_t cnt_reg;
    logic [1:0] which_reg;
    logic [CntW-1:0] x_reg;
    logic [4:0] e_reg;
    logic [32:0] m_reg;
    logic [31:0] frac_reg;
    logic [5:0] it_reg;
    logic signed [40:0] acc_reg;
    logic [26:0] t_reg;
    logic [58:0] prod_reg;
    logic [DistW-1:0] dist_reg;
    logic [1:0] status_reg;

    logic signed [CntW+2:0] a_val, b_val;
    logic [65:0] sq;
    logic [33:0] sq_sh;
    logic [36:0] lg;
    logic signed [40:0] acc_add;
    logic [59:0] rnd;

    assign a_val = $signed({3'b0, in_counts.n}) - $signed({2'b0, in_counts.ts, 1'b0})
                 - $signed({3'b0, in_counts.tv});
    assign b_val = $signed({3'b0, in_counts.n}) - $signed({2'b0, in_counts.tv, 1'b0});
    assign sq = m_reg * m_reg;
    assign sq_sh = sq[64:31];
    assign lg = {e_reg, frac_reg};

    always_comb
    begin
        case (which_reg)
            2'd0: acc_add = 41'($signed({4'b0, lg}) * 3);
            2'd1: acc_add = -41'($signed({4'b0, lg}) * 2);
            default: acc_add = -41'($signed({4'b0, lg}));
        endcase
    end

    // The product stays below 2^56, so the rounded value always fits the distance field.
    assign rnd = {1'b0, prod_reg} + 60'(64'd1 << 35);
    assign in_pop = (state_reg == S_IDLE) && !in_empty;
    assign res_valid = state_reg == S_OUT;
    assign res_counts = cnt_reg;
    assign res_dist = dist_reg;
    assign res_status = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            which_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (!in_empty)
                    begin
                        cnt_reg <= in_counts;
                        which_reg <= 2'd0;
                        x_reg <= in_counts.n;
                        acc_reg <= '0;
                        if (in_counts.n == '0)
                        begin
                            status_reg <= StatusNoCols;
                            dist_reg <= '0;
                            state_reg <= S_OUT;
                        end
                        else if (a_val <= 0 || b_val <= 0)
                        begin
                            status_reg <= StatusLogArg;
                            dist_reg <= '1;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            status_reg <= StatusOk;
                            e_reg <= '0;
                            state_reg <= S_NORM;
                        end
                    end
                S_NORM:
                    if (e_reg < 5'd16 && (x_reg >> (e_reg + 1'b1)) != '0)
                        e_reg <= e_reg + 1'b1;
                    else
                    begin
                        m_reg <= 33'({16'b0, x_reg} << (5'd31 - e_reg));
                        frac_reg <= '0;
                        it_reg <= '0;
                        state_reg <= S_SQ;
                    end
                S_SQ:
                begin
                    if (sq_sh[33:32] != 2'b0)
                    begin
                        m_reg <= sq_sh[33:1];
                        frac_reg <= {frac_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        m_reg <= sq_sh[32:0];
                        frac_reg <= {frac_reg[30:0], 1'b0};
                    end
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == 6'd31)
                        state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    acc_reg <= acc_reg + acc_add;
                    e_reg <= '0;
                    if (which_reg == 2'd2)
                        state_reg <= S_MUL;
                    else
                    begin
                        which_reg <= which_reg + 1'b1;
                        x_reg <= (which_reg == 2'd0)
                            ? CntW'(cnt_reg.n - {cnt_reg.ts[CntW-2:0], 1'b0} - cnt_reg.tv)
                            : CntW'(cnt_reg.n - {cnt_reg.tv[CntW-2:0], 1'b0});
                        state_reg <= S_NORM;
                    end
                end
                S_MUL:
                begin
                    if (acc_reg < 0)
                        t_reg <= '0;
                    else
                        t_reg <= 27'(acc_reg >>> 14);
                    state_reg <= S_PROD;
                end
                S_PROD:
                begin
                    prod_reg <= t_reg * Ln2Q32;
                    state_reg <= S_RND;
                end
                S_RND:
                begin
                    dist_reg <= rnd[DistW+35:36];
                    state_reg <= S_OUT;
                end
                S_OUT:
                    if (res_pop)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/core/k2p_pair_distance.sv
// Top level of the Kimura two-parameter pair distance block.
// Usage: columns of an aligned sequence pair enter on the push/full channel,
// one transfer per cycle while full is low; base_a and base_b are ASCII codes
// and last marks the final column of the pair. The front end counts columns,
// transitions and transversions at one column per cycle and, on the last
// column, hands the totals to a four-entry queue. The distance engine takes
// one set of totals at a time and evaluates three base-two logarithms, each
// by normalisation, a squaring loop that yields one fraction bit per squaring
// and a summing step, then scales by ln 2 in shift, multiply and round states;
// it goes straight to its output when there are no columns or a log argument
// is not positive. Results appear on the empty/pop channel and stay there
// until popped. While the engine is busy or the receiver stalls, columns keep
// streaming until the queue holds three sets, when full is raised. Reset
// clears the counts, the queue and the engine. The engine takes no new set of
// totals until its result is popped, so the sustained pair rate is set by the
// engine and chiefly by its squaring loop.
`timescale 1ns / 1ps
`include "k2p_pair_distance_defines.svh"
module k2p_pair_distance
    import k2p_pkg::*;
#(
    parameter int MAX_COLUMNS = DefaultMaxColumns
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       base_a,
    input  logic [7:0]       base_b,
    input  logic             last,
    output logic             empty,
    input  logic             pop,
    output logic [CntW-1:0]  column_total,
    output logic [CntW-1:0]  transition_total,
    output logic [CntW-1:0]  transversion_total,
    output logic [DistW-1:0] distance,
    output logic [1:0]       status
);
    logic accept;
    logic f_valid;
    counts_t f_counts;
    logic q_full, q_empty, q_rd;
    counts_t q_data;
    logic res_valid;
    counts_t res_counts;

    // The queue raises full at three sets so the one in flight in the front stage always fits.
    assign full = q_full;
    assign accept = push && !full;

    k2p_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(accept),
        .base_a(base_a), .base_b(base_b), .last(last),
        .out_valid(f_valid), .out_counts(f_counts)
    );

    k2p_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr(f_valid), .wdata(f_counts),
        .full(q_full), .empty(q_empty), .rd(q_rd), .rdata(q_data)
    );

    k2p_back u_back (
        .clk(clk), .rst_n(rst_n), .in_empty(q_empty), .in_counts(q_data),
        .in_pop(q_rd), .res_valid(res_valid), .res_pop(pop && !empty),
        .res_counts(res_counts), .res_dist(distance), .res_status(status)
    );

    assign empty = !res_valid;
    assign column_total = res_counts.n;
    assign transition_total = res_counts.ts;
    assign transversion_total = res_counts.tv;

    `K2P_ASSERT(a_no_overflow, clk, rst_n, f_valid |-> !$past(q_full))
    `K2P_ASSERT(a_no_underflow, clk, rst_n, !(q_rd && q_empty))
    `K2P_ASSERT(a_status_range, clk, rst_n, empty || status != 2'd3)
endmodule

FILE: sim/k2p_pair_distance_tb.sv
// Self-checking testbench for the Kimura two-parameter pair distance block.
`timescale 1ns / 1ps
module k2p_pair_distance_tb;
    import k2p_pkg::*;

    // The column counter stops at the smaller of the column limit and its 17-bit range.
    localparam int unsigned ColumnCap = (DefaultMaxColumns < 131071) ? DefaultMaxColumns : 131071;
    localparam logic [23:0] DistanceMax = 24'hFFFFFF;
    localparam int unsigned CycleLimit = 1500000;
    localparam int RandomColumns = 1400;
    localparam int IdlePct = 32;

    localparam logic [7:0] CharA = 8'h41;
    localparam logic [7:0] CharC = 8'h43;
    localparam logic [7:0] CharG = 8'h47;
    localparam logic [7:0] CharT = 8'h54;
    localparam logic [7:0] CharGap = 8'h2D;
    localparam logic [7:0] CharLowA = 8'h61;
    localparam logic [7:0] CharLowG = 8'h67;

    // Purines come first, so that the upper bit of the code gives the class.
    typedef enum int {NucA = 0, NucG = 1, NucC = 2, NucT = 3, NucOther = -1} nucleotide_t;

    typedef struct {
        logic [CntW-1:0]  columns;
        logic [CntW-1:0]  transitions;
        logic [CntW-1:0]  transversions;
        logic [DistW-1:0] dist_val;
        logic [1:0]       code;
    } pair_totals_t;

    // Keeps its own copy of the running counts, works out the totals and the
    // distance of every pair whose last column has been transferred, and
    // compares the results that come out against them in order.
    class pair_scoreboard;
        int unsigned  column_cnt;
        int unsigned  transition_cnt;
        int unsigned  transversion_cnt;
        pair_totals_t awaited[$];
        int           errors;

        function nucleotide_t classify(logic [7:0] c);
            case (c)
                CharA:   return NucA;
                CharG:   return NucG;
                CharC:   return NucC;
                CharT:   return NucT;
                default: return NucOther;
            endcase
        endfunction

        // Base-two logarithm in Q.32: exact integer part, then one fraction
        // bit per truncated squaring of the normalised mantissa.
        function longint unsigned log2_q32(longint unsigned x);
            int unsigned      e;
            longint unsigned  m;
            longint unsigned  frac;
            e = 0;
            frac = 0;
            while (e < 31 && (x >> (e + 1)) != 0)
                e++;
            m = x << (31 - e);
            for (int i = 0; i < 32; i++)
            begin
                m = (m * m) >> 31;
                frac = frac << 1;
                if (m >= 64'h1_0000_0000)
                begin
                    m = m >> 1;
                    frac = frac | 64'd1;
                end
            end
            return (longint'(e) << 32) | frac;
        endfunction

        function pair_totals_t pair_distance();
            pair_totals_t    r;
            longint          arg_a;
            longint          arg_b;
            longint          sum;
            longint unsigned scaled;
            r.columns = CntW'(column_cnt);
            r.transitions = CntW'(transition_cnt);
            r.transversions = CntW'(transversion_cnt);
            r.code = StatusOk;
            r.dist_val = '0;
            if (column_cnt == 0)
            begin
                r.code = StatusNoCols;
                return r;
            end
            arg_a = longint'(column_cnt) - 2 * longint'(transition_cnt) - longint'(transversion_cnt);
            arg_b = longint'(column_cnt) - 2 * longint'(transversion_cnt);
            if (arg_a <= 0 || arg_b <= 0)
            begin
                r.code = StatusLogArg;
                r.dist_val = DistanceMax;
                return r;
            end
            sum = 3 * longint'(log2_q32(column_cnt)) - 2 * longint'(log2_q32(arg_a))
                  - longint'(log2_q32(arg_b));
            if (sum < 0)
                sum = 0;
            scaled = longint'(unsigned'(sum)) >> 14;
            scaled = (scaled * longint'(Ln2Q32) + (64'd1 << 35)) >> 36;
            r.dist_val = (scaled > DistanceMax) ? DistanceMax : scaled[DistW-1:0];
            return r;
        endfunction

        function void note_column(logic [7:0] a, logic [7:0] b, logic fin);
            nucleotide_t ca;
            nucleotide_t cb;
            ca = classify(a);
            cb = classify(b);
            if (column_cnt < ColumnCap)
            begin
                column_cnt++;
                if (ca != NucOther && cb != NucOther && ca != cb)
                begin
                    if ((int'(ca) >> 1) == (int'(cb) >> 1))
                        transition_cnt++;
                    else
                        transversion_cnt++;
                end
            end
            if (fin)
            begin
                awaited.push_back(pair_distance());
                column_cnt = 0;
                transition_cnt = 0;
                transversion_cnt = 0;
            end
        endfunction

        function void complain(string what);
            errors++;
            if (errors <= 10)
                $display("%0t: %s", $realtime, what);
        endfunction

        function void check_result(pair_totals_t got);
            pair_totals_t want;
            if (awaited.size() == 0)
            begin
                complain($sformatf("result with no pair outstanding: n=%0d ts=%0d tv=%0d d=%06h st=%0d",
                                   got.columns, got.transitions, got.transversions, got.dist_val,
                                   got.code));
                return;
            end
            want = awaited.pop_front();
            if (got.columns !== want.columns || got.transitions !== want.transitions
                || got.transversions !== want.transversions || got.dist_val !== want.dist_val
                || got.code !== want.code)
                complain($sformatf("mismatch: expected n=%0d ts=%0d tv=%0d d=%06h st=%0d, got n=%0d ts=%0d tv=%0d d=%06h st=%0d",
                                   want.columns, want.transitions, want.transversions,
                                   want.dist_val, want.code, got.columns, got.transitions,
                                   got.transversions, got.dist_val, got.code));
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             push;
    logic             full;
    logic [7:0]       base_a;
    logic [7:0]       base_b;
    logic             last;
    logic             empty;
    logic             pop;
    logic [CntW-1:0]  column_total;
    logic [CntW-1:0]  transition_total;
    logic [CntW-1:0]  transversion_total;
    logic [DistW-1:0] distance;
    logic [1:0]       status;

    pair_scoreboard   sb;
    bit               steady;
    int unsigned      cycle_cnt;
    int               columns_sent;

    k2p_pair_distance u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .full               (full),
        .base_a             (base_a),
        .base_b             (base_b),
        .last               (last),
        .empty              (empty),
        .pop                (pop),
        .column_total       (column_total),
        .transition_total   (transition_total),
        .transversion_total (transversion_total),
        .distance           (distance),
        .status             (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a run that has not finished by now has hung somewhere.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CycleLimit)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offers one column and holds it until a transfer takes place. Every
    // signal gets at most one nonblocking assignment per clock edge, and
    // outputs are read straight after the edge, so they still hold the
    // values that the block itself saw at that edge.
    task automatic send_column(input logic [7:0] a, input logic [7:0] b, input logic fin);
        while (!steady && $urandom_range(99) < IdlePct)
        begin
            push <= 1'b0;
            base_a <= 8'($urandom);
            base_b <= 8'($urandom);
            last <= 1'($urandom);
            @(posedge clk);
        end
        push <= 1'b1;
        base_a <= a;
        base_b <= b;
        last <= fin;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_column(a, b, fin);
        columns_sent++;
    endtask

    function automatic logic [7:0] random_base();
        case ($urandom_range(3))
            0:       return CharA;
            1:       return CharC;
            2:       return CharG;
            default: return CharT;
        endcase
    endfunction

    // One aligned pair: mostly well-formed uppercase bases, with a chosen
    // share of mismatches and a share of arbitrary bytes as noise.
    task automatic send_pair(input int len, input int mismatch_pct, input int noise_pct);
        logic [7:0] a;
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            a = random_base();
            b = ($urandom_range(99) < mismatch_pct) ? random_base() : a;
            if ($urandom_range(99) < noise_pct)
                a = 8'($urandom);
            if ($urandom_range(99) < noise_pct)
                b = 8'($urandom);
            send_column(a, b, i == len - 1);
        end
    endtask

    // Result side: pops at random, with the same quiet stretch as the sender.
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                sb.check_result('{column_total, transition_total, transversion_total,
                                  distance, status});
            pop <= steady || ($urandom_range(99) >= IdlePct);
        end
    end

    initial
    begin
        int len;
        sb = new();
        steady = 1'b0;
        cycle_cnt = 0;
        columns_sent = 0;
        rst_n = 1'b0;
        push = 1'b0;
        base_a = '0;
        base_b = '0;
        last = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single-column pairs of each kind, including a transition
        // and a transversion on their own (the log argument goes negative),
        // lowercase letters, a gap and the extreme byte values.
        send_column(CharA, CharA, 1'b1);
        send_column(CharA, CharG, 1'b1);
        send_column(CharC, CharT, 1'b1);
        send_column(CharA, CharC, 1'b1);
        send_column(CharG, CharT, 1'b1);
        send_column(CharLowA, CharLowG, 1'b1);
        send_column(CharGap, CharA, 1'b1);
        send_column(8'h00, 8'hFF, 1'b1);
        send_column(8'hFF, 8'h00, 1'b1);
        send_column(8'h55, 8'hAA, 1'b1);
        // A longer pair with one of each kind of mismatch and a finite distance.
        send_column(CharA, CharA, 1'b0);
        send_column(CharG, CharA, 1'b0);
        send_column(CharT, CharT, 1'b0);
        send_column(CharC, CharG, 1'b0);
        send_column(CharC, CharC, 1'b0);
        send_column(CharT, CharT, 1'b0);
        send_column(CharG, CharG, 1'b0);
        send_column(CharLowA, CharT, 1'b0);
        send_column(CharA, CharA, 1'b1);
        // Transversions only, with the second argument exactly zero.
        send_column(CharA, CharT, 1'b0);
        send_column(CharA, CharA, 1'b1);

        // Random pairs, mostly short, a few long, with a quiet stretch in
        // the middle where neither side idles.
        while (columns_sent < RandomColumns)
        begin
            steady = (columns_sent > 600 && columns_sent < 900);
            len = ($urandom_range(19) == 0) ? $urandom_range(300, 60) : $urandom_range(30, 1);
            send_pair(len, $urandom_range(60), ($urandom_range(3) == 0) ? 15 : 0);
        end
        steady = 1'b0;
        push <= 1'b0;

        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
